FILE: design/ssd1306_i2c_write_framer_assert.svh
// Assertion macros for the framer modules; ssdif_back includes them.
`ifndef SSD1306_I2C_WRITE_FRAMER_ASSERT_SVH
`define SSD1306_I2C_WRITE_FRAMER_ASSERT_SVH

// cond must hold at every edge outside reset
`define SSDIF_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("ssdif assertion failed");

// cons must hold in the same cycle as ante
`define SSDIF_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ssdif assertion failed");

// cons must hold in the cycle after ante
`define SSDIF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ssdif assertion failed");

`endif

FILE: design/ssdif_pkg.sv
package ssdif_pkg;

   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_BIT   = 2'd1,
      KIND_ACK   = 2'd2,
      KIND_STOP  = 2'd3
   } kind_type;

   localparam logic [2:0] OP_COMMAND    = 3'd0;
   localparam logic [2:0] OP_SET_POS    = 3'd1;
   localparam logic [2:0] OP_BEGIN_DATA = 3'd2;
   localparam logic [2:0] OP_DATA       = 3'd3;
   localparam logic [2:0] OP_STOP       = 3'd4;

   localparam int MAX_BYTES = 5;
   localparam int QDEPTH    = 2;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_SLAVE_ADDR = 1'b0;

   localparam logic [7:0] ADDR_RESET   = 8'h78;
   localparam logic [7:0] CTRL_CMD     = 8'h00;
   localparam logic [7:0] CTRL_DATA    = 8'h40;
   localparam logic [7:0] PAGE_BASE    = 8'hB0;
   localparam logic [7:0] COL_HI_BASE  = 8'h10;
   localparam logic [7:0] COL_LO_MASK  = 8'h0F;
   localparam logic [7:0] COL_LO_FORCE = 8'h01;

   typedef struct packed {
      logic                      has_start;
      logic                      has_stop;
      logic [2:0]                nbytes;
      logic [MAX_BYTES-1:0][7:0] bytes;
   } desc_type;

endpackage

FILE: design/ssdif_queue.sv
module ssdif_queue import ssdif_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_en,
   input  desc_type wr_data,
   output logic     full,
   input  logic     rd_en,
   output desc_type rd_data,
   output logic     empty
);

   localparam int PTR_W = $clog2(QDEPTH);

   desc_type             mem_ff [QDEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]       count_ff, count_in;

   assign full    = (count_ff == (PTR_W+1)'(QDEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QDEPTH-1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QDEPTH-1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (wr_en && !rd_en) begin
         count_in = (PTR_W+1)'(count_ff + 1'b1);
      end else if (!wr_en && rd_en) begin
         count_in = (PTR_W+1)'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: design/ssdif_front.sv
module ssdif_front import ssdif_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   input  logic                  push,
   input  logic [2:0]            req_opcode,
   input  logic [7:0]            req_byte_value,
   input  logic [6:0]            req_column,
   input  logic [2:0]            req_page,
   input  logic                  q_full,
   output logic                  q_push,
   output desc_type              q_data
);

   logic [7:0] slave_addr_ff, slave_addr_in;
   logic       csr_write;
   logic       known_op;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == REG_SLAVE_ADDR);
   assign prdata    = (paddr[2] == REG_SLAVE_ADDR) ?
                      CSR_DATA_W'(slave_addr_ff) : '0;

   always_comb begin
      slave_addr_in = csr_write ? pwdata[7:0] : slave_addr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_addr_ff <= ADDR_RESET;
      end else begin
         slave_addr_ff <= slave_addr_in;
      end
   end

   always_comb begin
      q_data          = '0;
      known_op        = 1'b1;
      q_data.bytes[0] = slave_addr_ff;
      unique case (req_opcode)
         OP_COMMAND: begin
            q_data.has_start = 1'b1;
            q_data.has_stop  = 1'b1;
            q_data.nbytes    = 3'd3;
            q_data.bytes[1]  = CTRL_CMD;
            q_data.bytes[2]  = req_byte_value;
         end
         OP_SET_POS: begin
            q_data.has_start = 1'b1;
            q_data.has_stop  = 1'b1;
            q_data.nbytes    = 3'd5;
            q_data.bytes[1]  = CTRL_CMD;
            q_data.bytes[2]  = PAGE_BASE | {5'd0, req_page};
            q_data.bytes[3]  = COL_HI_BASE | {5'd0, req_column[6:4]};
            q_data.bytes[4]  = (COL_LO_MASK & {4'd0, req_column[3:0]}) | COL_LO_FORCE;
         end
         OP_BEGIN_DATA: begin
            q_data.has_start = 1'b1;
            q_data.nbytes    = 3'd2;
            q_data.bytes[1]  = CTRL_DATA;
         end
         OP_DATA: begin
            q_data.nbytes    = 3'd1;
            q_data.bytes[0]  = req_byte_value;
         end
         OP_STOP: begin
            q_data.has_stop  = 1'b1;
         end
         default: begin
            known_op = 1'b0;
         end
      endcase
   end

   // unused opcodes are taken and dropped
   assign q_push = push && !q_full && known_op;

endmodule

FILE: design/ssdif_back.sv
`include "ssd1306_i2c_write_framer_assert.svh"

module ssdif_back import ssdif_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  desc_type   q_head,
   output logic       q_pop,
   output logic       empty,
   input  logic       pop,
   output logic [1:0] rsp_symbol_kind,
   output logic       rsp_sda_level,
   output logic       rsp_last_symbol
);

   typedef enum logic [1:0] {
      PH_START,
      PH_BYTES,
      PH_STOP
   } phase_type;

   desc_type   cur_ff, cur_in;
   logic       cur_valid_ff, cur_valid_in;
   phase_type  phase_ff, phase_in;
   logic [2:0] byte_idx_ff, byte_idx_in;
   logic [3:0] bit_idx_ff, bit_idx_in;

   logic       out_valid_ff, out_valid_in;
   kind_type   out_kind_ff, out_kind_in;
   logic       out_sda_ff, out_sda_in;
   logic       out_last_ff, out_last_in;

   kind_type   sym_kind;
   logic       sym_sda;
   logic       sym_last;
   logic       slot_free;
   logic       emit;
   logic       run_done;
   logic       load;
   logic       last_byte;
   logic [7:0] cur_byte;

   assign cur_byte  = cur_ff.bytes[byte_idx_ff];
   assign last_byte = (byte_idx_ff == 3'(cur_ff.nbytes - 3'd1));

   always_comb begin
      sym_kind = KIND_STOP;
      sym_sda  = 1'b1;
      sym_last = 1'b1;
      unique case (phase_ff)
         PH_START: begin
            sym_kind = KIND_START;
            sym_sda  = 1'b0;
            sym_last = (cur_ff.nbytes == 3'd0) && !cur_ff.has_stop;
         end
         PH_BYTES: begin
            if (bit_idx_ff[3]) begin
               sym_kind = KIND_ACK;
               sym_sda  = 1'b1;
               sym_last = last_byte && !cur_ff.has_stop;
            end else begin
               sym_kind = KIND_BIT;
               sym_sda  = cur_byte[~bit_idx_ff[2:0]];
               sym_last = 1'b0;
            end
         end
         PH_STOP: begin
            sym_kind = KIND_STOP;
            sym_sda  = 1'b1;
            sym_last = 1'b1;
         end
         default: begin
            sym_kind = KIND_STOP;
            sym_sda  = 1'b1;
            sym_last = 1'b1;
         end
      endcase
   end

   assign slot_free = !out_valid_ff || pop;
   assign emit      = cur_valid_ff && slot_free;
   assign run_done  = emit && sym_last;
   assign load      = !q_empty && (!cur_valid_ff || run_done);
   assign q_pop     = load;

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      phase_in     = phase_ff;
      byte_idx_in  = byte_idx_ff;
      bit_idx_in   = bit_idx_ff;
      if (load) begin
         cur_in       = q_head;
         cur_valid_in = 1'b1;
         byte_idx_in  = '0;
         bit_idx_in   = '0;
         if (q_head.has_start) begin
            phase_in = PH_START;
         end else if (q_head.nbytes != 3'd0) begin
            phase_in = PH_BYTES;
         end else begin
            phase_in = PH_STOP;
         end
      end else if (run_done) begin
         cur_valid_in = 1'b0;
      end else if (emit) begin
         unique case (phase_ff)
            PH_START: begin
               phase_in = (cur_ff.nbytes != 3'd0) ? PH_BYTES : PH_STOP;
            end
            PH_BYTES: begin
               if (bit_idx_ff[3]) begin
                  bit_idx_in = '0;
                  if (last_byte) begin
                     phase_in = PH_STOP;
                  end else begin
                     byte_idx_in = 3'(byte_idx_ff + 3'd1);
                  end
               end else begin
                  bit_idx_in = 4'(bit_idx_ff + 4'd1);
               end
            end
            PH_STOP: begin
               phase_in = PH_STOP;
            end
            default: begin
               phase_in = PH_STOP;
            end
         endcase
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_kind_in  = out_kind_ff;
      out_sda_in   = out_sda_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_kind_in  = sym_kind;
         out_sda_in   = sym_sda;
         out_last_in  = sym_last;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_START;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
      end
      cur_ff      <= cur_in;
      byte_idx_ff <= byte_idx_in;
      bit_idx_ff  <= bit_idx_in;
      out_kind_ff <= out_kind_in;
      out_sda_ff  <= out_sda_in;
      out_last_ff <= out_last_in;
   end

   assign empty           = !out_valid_ff;
   assign rsp_symbol_kind = out_kind_ff;
   assign rsp_sda_level   = out_sda_ff;
   assign rsp_last_symbol = out_last_ff;

   `SSDIF_ASSERT_IMPLIES(a_stop_ends_run, clock, reset,
      out_valid_ff && (out_kind_ff == KIND_STOP), out_last_ff)
   `SSDIF_ASSERT_IMPLIES(a_start_not_last, clock, reset,
      out_valid_ff && (out_kind_ff == KIND_START), !out_last_ff)
   `SSDIF_ASSERT_ALWAYS(a_pop_needs_head, clock, reset, !(q_pop && q_empty))
   `SSDIF_ASSERT_NEXT(a_emit_fills_slot, clock, reset, emit, out_valid_ff)

endmodule

FILE: design/ssd1306_i2c_write_framer.sv
// Write-only I2C symbol framer for an SSD1306-style OLED controller. Each opcode taken on the
// request queue becomes a run of bus symbols (start, data bit, ack slot, stop) on the response
// queue, one symbol per clock when pop keeps up; last_symbol marks the end of each run. A data
// byte beat yields 9 symbols, begin data 19, command 29, set position 47, stop 1; opcodes 5 to
// 7 are taken and yield nothing. The output rate is set by the back-end sequencer, which emits
// one symbol per cycle while its output slot is free; the front end classifies one request per
// cycle, when not full, into a two-entry descriptor queue, so push sees full only when two runs
// wait behind the active one. The slave address byte (reset 0x78) sits at byte address 0 of the
// APB port and is sampled when a request is taken; acknowledge is never sampled.
module ssd1306_i2c_write_framer import ssdif_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic [2:0]            req_opcode,
   input  logic [7:0]            req_byte_value,
   input  logic [6:0]            req_column,
   input  logic [2:0]            req_page,
   output logic                  empty,
   input  logic                  pop,
   output logic [1:0]            rsp_symbol_kind,
   output logic                  rsp_sda_level,
   output logic                  rsp_last_symbol,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic     q_push;
   logic     q_full;
   logic     q_pop;
   logic     q_empty;
   desc_type q_wr_data;
   desc_type q_head;

   assign full = q_full;

   ssdif_front u_front (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .push           (push),
      .req_opcode     (req_opcode),
      .req_byte_value (req_byte_value),
      .req_column     (req_column),
      .req_page       (req_page),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_data         (q_wr_data)
   );

   ssdif_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (q_wr_data),
      .full    (q_full),
      .rd_en   (q_pop),
      .rd_data (q_head),
      .empty   (q_empty)
   );

   ssdif_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .empty           (empty),
      .pop             (pop),
      .rsp_symbol_kind (rsp_symbol_kind),
      .rsp_sda_level   (rsp_sda_level),
      .rsp_last_symbol (rsp_last_symbol)
   );

endmodule

FILE: tb/tb_ssd1306_i2c_write_framer.sv
`timescale 1ns / 100ps

module tb_ssd1306_i2c_write_framer;
   import ssdif_pkg::*;

   localparam int LIMIT        = 1_000_000;
   localparam int DRAIN_SETTLE = 8;
   localparam int RANDOM_ITEMS = 300;
   localparam logic [CSR_ADDR_W-1:0] SLAVE_ADDR_OFFSET = CSR_ADDR_W'(4 * REG_SLAVE_ADDR);
   localparam logic [2:0] OP_UNUSED_FIRST = OP_STOP + 3'd1;
   localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

   typedef struct {
      kind_type kind;
      logic     sda;
      logic     last;
   } bus_symbol_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  push = 1'b0;
   logic                  full;
   logic [2:0]            req_opcode = '0;
   logic [7:0]            req_byte_value = '0;
   logic [6:0]            req_column = '0;
   logic [2:0]            req_page = '0;
   logic                  empty;
   logic                  pop = 1'b0;
   logic [1:0]            rsp_symbol_kind;
   logic                  rsp_sda_level;
   logic                  rsp_last_symbol;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   bus_symbol_type symbols_due[$];
   logic [7:0]  addr_byte_model = ADDR_RESET;
   int          mismatch_count = 0;
   int          cycle_count = 0;
   int          stall_left = 0;
   bit          send_idle_en = 1'b1;
   bit          recv_idle_en = 1'b1;

   ssd1306_i2c_write_framer dut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_opcode      (req_opcode),
      .req_byte_value  (req_byte_value),
      .req_column      (req_column),
      .req_page        (req_page),
      .empty           (empty),
      .pop             (pop),
      .rsp_symbol_kind (rsp_symbol_kind),
      .rsp_sda_level   (rsp_sda_level),
      .rsp_last_symbol (rsp_last_symbol),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 100)
         $display("MISMATCH cycle %0d: %s", cycle_count, what);
   endtask

   // ---------------- symbol predictor ----------------
   task automatic add_symbol(input kind_type kind, input logic sda);
      bus_symbol_type s;
      s.kind = kind;
      s.sda  = sda;
      s.last = 1'b0;
      symbols_due.push_back(s);
   endtask

   task automatic add_byte(input logic [7:0] value);
      for (int b = 7; b >= 0; b--)
         add_symbol(KIND_BIT, value[b]);
      add_symbol(KIND_ACK, 1'b1);
   endtask

   task automatic add_open(input logic [7:0] control);
      add_symbol(KIND_START, 1'b0);
      add_byte(addr_byte_model);
      add_byte(control);
   endtask

   task automatic frame_opcode(input logic [2:0] op, input logic [7:0] bv,
                               input logic [6:0] col, input logic [2:0] pg);
      int             first;
      bus_symbol_type tail;
      first = symbols_due.size();
      case (op)
         OP_COMMAND: begin
            add_open(CTRL_CMD);
            add_byte(bv);
            add_symbol(KIND_STOP, 1'b1);
         end
         OP_SET_POS: begin
            add_open(CTRL_CMD);
            add_byte(PAGE_BASE + {5'b0, pg});
            add_byte(COL_HI_BASE | {5'b0, col[6:4]});
            add_byte(({1'b0, col} & COL_LO_MASK) | COL_LO_FORCE);
            add_symbol(KIND_STOP, 1'b1);
         end
         OP_BEGIN_DATA: add_open(CTRL_DATA);
         OP_DATA:       add_byte(bv);
         OP_STOP:       add_symbol(KIND_STOP, 1'b1);
         default: ;
      endcase
      if (symbols_due.size() > first) begin
         tail = symbols_due.pop_back();
         tail.last = 1'b1;
         symbols_due.push_back(tail);
      end
   endtask

   // ---------------- request side ----------------
   task automatic send_item(input logic [2:0] op, input logic [7:0] bv,
                            input logic [6:0] col, input logic [2:0] pg);
      if (send_idle_en && $urandom_range(0, 4) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      push           <= 1'b1;
      req_opcode     <= op;
      req_byte_value <= bv;
      req_column     <= col;
      req_page       <= pg;
      @(posedge clock);
      while (full) @(posedge clock);
      frame_opcode(op, bv, col, pg);
   endtask

   task automatic send_op(input logic [2:0] op);
      send_item(op, 8'($urandom), 7'($urandom), 3'($urandom));
   endtask

   task automatic wait_drain();
      push <= 1'b0;
      @(posedge clock);
      while (symbols_due.size() != 0) @(posedge clock);
      repeat (DRAIN_SETTLE) @(posedge clock);
   endtask

   // ---------------- register port ----------------
   task automatic csr_write(input logic [7:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= SLAVE_ADDR_OFFSET;
      pwdata  <= {24'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      addr_byte_model = value;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read_check();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= SLAVE_ADDR_OFFSET;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[7:0] !== addr_byte_model)
         report_mismatch($sformatf("address readback %02h, want %02h",
                                   prdata[7:0], addr_byte_model));
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // ---------------- result side ----------------
   always @(posedge clock) begin
      bus_symbol_type due;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (symbols_due.size() == 0) begin
               report_mismatch($sformatf("symbol kind %0d with nothing due", rsp_symbol_kind));
            end else begin
               due = symbols_due.pop_front();
               if (rsp_symbol_kind !== due.kind)
                  report_mismatch($sformatf("symbol_kind %0d, want %0d",
                                            rsp_symbol_kind, due.kind));
               if (rsp_sda_level !== due.sda)
                  report_mismatch($sformatf("sda_level %0b, want %0b (kind %0d)",
                                            rsp_sda_level, due.sda, due.kind));
               if (rsp_last_symbol !== due.last)
                  report_mismatch($sformatf("last_symbol %0b, want %0b (kind %0d)",
                                            rsp_last_symbol, due.last, due.kind));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
         end else if (recv_idle_en && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // ---------------- tests ----------------
   task automatic test_directed_opcodes();
      csr_read_check();
      send_item(OP_COMMAND, 8'h00, 7'd0, 3'd0);
      send_item(OP_COMMAND, 8'hFF, 7'd127, 3'd7);
      send_item(OP_SET_POS, 8'h00, 7'd0, 3'd0);
      send_item(OP_SET_POS, 8'hFF, 7'd127, 3'd7);
      // even low nibble: bit 0 comes out forced high
      send_item(OP_SET_POS, 8'h00, 7'h5E, 3'd3);
      send_item(OP_BEGIN_DATA, 8'hFF, 7'd127, 3'd7);
      send_item(OP_DATA, 8'h00, 7'd0, 3'd0);
      send_item(OP_DATA, 8'hFF, 7'd0, 3'd0);
      send_item(OP_DATA, 8'hA5, 7'd0, 3'd0);
      send_item(OP_STOP, 8'hFF, 7'd127, 3'd7);
      // out-of-order bus use is framed as asked
      send_item(OP_STOP, 8'h00, 7'd0, 3'd0);
      send_item(OP_DATA, 8'h5A, 7'd127, 3'd7);
      send_item(OP_BEGIN_DATA, 8'h00, 7'd0, 3'd0);
      send_item(OP_BEGIN_DATA, 8'h00, 7'd0, 3'd0);
      for (logic [3:0] op = 4'(OP_UNUSED_FIRST); op <= 4'(OP_UNUSED_LAST); op++)
         send_item(op[2:0], 8'hFF, 7'd127, 3'd7);
      send_item(OP_DATA, 8'h3C, 7'd0, 3'd0);
      wait_drain();
   endtask

   task automatic test_address_settings();
      logic [7:0] settings[3];
      settings = '{8'h00, 8'hFF, 8'($urandom)};
      foreach (settings[i]) begin
         wait_drain();
         csr_write(settings[i]);
         csr_read_check();
         send_op(OP_COMMAND);
         send_op(OP_SET_POS);
         send_op(OP_BEGIN_DATA);
         send_op(OP_DATA);
         send_op(OP_STOP);
      end
      wait_drain();
   endtask

   task automatic test_pause_for_drain();
      logic [2:0] ops[6];
      ops = '{OP_BEGIN_DATA, OP_DATA, OP_UNUSED_FIRST, OP_STOP, OP_SET_POS, OP_COMMAND};
      foreach (ops[i]) begin
         send_op(ops[i]);
         wait_drain();
      end
   endtask

   task automatic test_random_traffic();
      int         sent;
      int         pick;
      int         nbytes;
      logic [2:0] op;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 24) == 0) begin
            wait_drain();
            csr_write(8'($urandom));
            send_idle_en = ($urandom_range(0, 3) != 0);
            recv_idle_en = ($urandom_range(0, 3) != 0);
         end
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            send_op(OP_BEGIN_DATA);
            nbytes = $urandom_range(1, 12);
            repeat (nbytes) send_op(OP_DATA);
            send_op(OP_STOP);
            sent += nbytes + 2;
         end else if (pick < 70) begin
            send_op(OP_COMMAND);
            sent++;
         end else if (pick < 82) begin
            send_op(OP_SET_POS);
            sent++;
         end else begin
            op = 3'($urandom_range(0, 7));
            send_op(op);
            if (op <= OP_STOP)
               sent++;
         end
      end
      wait_drain();
   endtask

   task automatic test_back_to_back();
      send_idle_en = 1'b0;
      recv_idle_en = 1'b0;
      csr_write(ADDR_RESET);
      send_op(OP_BEGIN_DATA);
      repeat (40) send_op(OP_DATA);
      send_op(OP_STOP);
      send_op(OP_COMMAND);
      send_op(OP_SET_POS);
      send_op(OP_COMMAND);
      wait_drain();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_opcodes();
      test_address_settings();
      test_pause_for_drain();
      test_random_traffic();
      test_back_to_back();
      repeat (20) @(posedge clock);
      if (symbols_due.size() != 0)
         report_mismatch($sformatf("%0d symbols never arrived", symbols_due.size()));
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
